// ===== rtl/rlvd_pkg.sv =====
package rlvd_pkg;

  localparam int LANES_DEFAULT = 8;
  localparam int LANES_MAX     = 8;

  // Register indexes, taken from paddr[2].
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_VOXEL_TOTAL = 1'b1;

  localparam logic MODE_BINARY = 1'b0;

  // A length byte of 255 in binary mode gives 254 voxels and keeps the value.
  localparam logic [7:0] LEN_HOLD     = 8'd255;
  localparam logic [7:0] LEN_HOLD_RUN = 8'd254;

  typedef enum logic [2:0] {
    PH_HEAD0 = 3'b001,
    PH_HEAD1 = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CLIP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_last;
  } code_word_t;

  typedef struct packed {
    logic [63:0] voxel_bytes;
    logic [3:0]  voxel_count;
    logic        run_end;
    logic        image_done;
  } voxel_word_t;

endpackage

// ===== rtl/run_length_voxel_decoder_unit.sv =====
// Channel   Direction  Handshake                 Word
// code      in         code_valid / code_stall   rlvd_pkg::code_word_t
// voxel     out        voxel_valid / voxel_stall rlvd_pkg::voxel_word_t
// apb       in/out     psel, penable, pready     decode_mode at 0, voxel_total at 4
//
// A run byte is accepted, then clipped against the voxels still missing, then
// sent as ceil(n / LANES) beats for a clipped run of n voxels; the beat loop
// shares one subtractor.
// The output register lets the last beat wait while the next byte is taken.
// Reset is synchronous; it clears the control and configuration registers and the voxel count to zero.
// A stalled output holds the beat loop until the register is taken.
module run_length_voxel_decoder_unit #(
  parameter int LANES = rlvd_pkg::LANES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  code_valid,
  output logic                  code_stall,
  input  rlvd_pkg::code_word_t  code_word,
  output logic                  voxel_valid,
  input  logic                  voxel_stall,
  output rlvd_pkg::voxel_word_t voxel_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rlvd_pkg::*;

  localparam logic [7:0] LANES_W = 8'(LANES);

  logic        decode_mode;
  logic [31:0] voxel_total;

  state_t      state;
  phase_t      phase;
  logic [7:0]  first_value;
  logic [7:0]  second_value;
  logic        use_second;
  logic [7:0]  held_length;
  logic [31:0] voxels_left;

  logic [7:0]  run_value;
  logic [7:0]  run_len;
  logic        run_last;
  logic        done_flag;
  logic [7:0]  remaining;

  logic        code_take;
  logic        cfg_write;
  logic        out_free;
  logic        beat_load;
  logic        run_byte;
  logic [7:0]  clip_len;
  logic [31:0] left_after;
  logic [7:0]  beat_count;
  voxel_word_t beat;

  phase_t      phase_next;
  logic        use_second_next;
  logic [31:0] voxels_left_next;

  assign pready     = 1'b1;
  assign code_stall = (state != ST_IDLE);
  assign code_take  = code_valid && (state == ST_IDLE);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign out_free   = !voxel_valid || !voxel_stall;
  assign beat_load  = (state == ST_EMIT) && out_free;
  assign run_byte   = (decode_mode == MODE_BINARY) ? (phase == PH_BODY)
                                                   : (phase != PH_HEAD0);

  always_comb begin
    unique case (paddr[2])
      REG_DECODE_MODE: prdata = {31'd0, decode_mode};
      REG_VOXEL_TOTAL: prdata = voxel_total;
      default:         prdata = 32'd0;
    endcase
  end

  // Clip the run to the voxels still missing.
  always_comb begin
    if ({24'd0, run_len} > voxels_left) begin
      clip_len = voxels_left[7:0];
    end else begin
      clip_len = run_len;
    end
    left_after = voxels_left - {24'd0, clip_len};
  end

  always_comb begin
    if (remaining < LANES_W) begin
      beat_count = remaining;
    end else begin
      beat_count = LANES_W;
    end
    for (int i = 0; i < LANES_MAX; i++) begin
      beat.voxel_bytes[8*i +: 8] = (8'(i) < beat_count) ? run_value : 8'h00;
    end
    beat.voxel_count = beat_count[3:0];
    beat.run_end     = (remaining <= LANES_W);
    beat.image_done  = (remaining <= LANES_W) && done_flag;
  end

  always_comb begin
    phase_next       = phase;
    use_second_next  = use_second;
    voxels_left_next = voxels_left;
    if (code_take) begin
      if (decode_mode == MODE_BINARY) begin
        unique case (phase)
          PH_HEAD0: phase_next = PH_HEAD1;
          PH_HEAD1: phase_next = PH_BODY;
          PH_BODY: begin
            if (code_word.code_byte != LEN_HOLD) begin
              use_second_next = !use_second;
            end
          end
          default: phase_next = PH_HEAD0;
        endcase
      end else begin
        phase_next = (phase == PH_HEAD0) ? PH_HEAD1 : PH_HEAD0;
      end
      if (code_word.stream_last) begin
        phase_next      = PH_HEAD0;
        use_second_next = 1'b0;
        // A header byte reloads at once; a run reloads after its clip.
        if (!run_byte) begin
          voxels_left_next = voxel_total;
        end
      end
    end
    if (state == ST_CLIP) begin
      voxels_left_next = run_last ? voxel_total : left_after;
    end
    // Any register write restarts the phase and the voxel count; a run already in flight still finishes.
    if (cfg_write) begin
      phase_next       = PH_HEAD0;
      use_second_next  = 1'b0;
      voxels_left_next = (paddr[2] == REG_VOXEL_TOTAL) ? pwdata : voxel_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= 1'b0;
      voxel_total  <= 32'd0;
      state        <= ST_IDLE;
      phase        <= PH_HEAD0;
      first_value  <= 8'd0;
      second_value <= 8'd0;
      use_second   <= 1'b0;
      held_length  <= 8'd0;
      voxels_left  <= 32'd0;
      voxel_valid  <= 1'b0;
    end else begin
      phase       <= phase_next;
      use_second  <= use_second_next;
      voxels_left <= voxels_left_next;

      if (beat_load) begin
        voxel_word  <= beat;
        voxel_valid <= 1'b1;
      end else if (!voxel_stall) begin
        voxel_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (code_take) begin
            run_last <= code_word.stream_last;
            if (decode_mode == MODE_BINARY) begin
              unique case (phase)
                PH_HEAD0: first_value <= code_word.code_byte;
                PH_HEAD1: second_value <= code_word.code_byte;
                PH_BODY: begin
                  run_value <= use_second ? second_value : first_value;
                  if (code_word.code_byte == LEN_HOLD) begin
                    run_len <= LEN_HOLD_RUN;
                  end else begin
                    run_len <= code_word.code_byte;
                  end
                  state <= ST_CLIP;
                end
                default: state <= ST_IDLE;
              endcase
            end else begin
              if (phase == PH_HEAD0) begin
                held_length <= code_word.code_byte;
              end else begin
                run_value <= code_word.code_byte;
                run_len   <= held_length;
                state     <= ST_CLIP;
              end
            end
          end
        end
        ST_CLIP: begin
          done_flag <= (left_after == 32'd0);
          remaining <= clip_len;
          state     <= (clip_len == 8'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            remaining <= remaining - beat_count;
            if (beat.run_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_write) begin
        if (paddr[2] == REG_VOXEL_TOTAL) begin
          voxel_total <= pwdata;
        end else begin
          decode_mode <= pwdata[0];
        end
      end
    end
  end

endmodule

// ===== test/voxel_stream_checker.sv =====
module voxel_stream_checker #(
  parameter int LANES = rlvd_pkg::LANES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  code_valid,
  input  logic                  code_stall,
  input  rlvd_pkg::code_word_t  code_word,
  input  logic                  voxel_valid,
  input  logic                  voxel_stall,
  input  rlvd_pkg::voxel_word_t voxel_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output int                    errors,
  output int                    pending,
  output int                    useful_words
);
  import rlvd_pkg::*;

  logic        decode_mode;
  logic [31:0] voxel_total;
  logic [31:0] voxels_left;
  phase_t      phase;
  logic [7:0]  first_value;
  logic [7:0]  second_value;
  logic [7:0]  held_length;
  logic        use_second;

  voxel_word_t expected_beats[$];
  voxel_word_t want;
  int          fail_count = 0;
  int          useful_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("%0t: %s: got %h, expected %h", $time, what, got, wanted);
    fail_count++;
  endtask

  task automatic restart_image();
    phase = PH_HEAD0;
    use_second = 1'b0;
    voxels_left = voxel_total;
  endtask

  // A run is clipped to the voxels still missing and split into beats of
  // at most LANES bytes; only the final beat of the run carries run_end.
  task automatic queue_run(input logic [7:0] value, input logic [31:0] length);
    logic [31:0] remaining;
    int          lanes_used;
    voxel_word_t beat;
    remaining = (length > voxels_left) ? voxels_left : length;
    voxels_left -= remaining;
    while (remaining > 0) begin
      lanes_used = (remaining < LANES) ? int'(remaining) : LANES;
      beat = '0;
      for (int i = 0; i < lanes_used; i++) begin
        beat.voxel_bytes[8*i +: 8] = value;
      end
      beat.voxel_count = 4'(lanes_used);
      beat.run_end = (remaining == lanes_used);
      beat.image_done = (remaining == lanes_used) && (voxels_left == 0);
      expected_beats.push_back(beat);
      remaining -= 32'(lanes_used);
    end
  endtask

  task automatic predict_word(input code_word_t w);
    logic [7:0]  run_value;
    logic [31:0] run_length;
    // Every word taken counts as a useful word.
    useful_count++;
    if (decode_mode == MODE_BINARY) begin
      case (phase)
        PH_HEAD0: begin
          first_value = w.code_byte;
          phase = PH_HEAD1;
        end
        PH_HEAD1: begin
          second_value = w.code_byte;
          phase = PH_BODY;
        end
        default: begin
          run_value = use_second ? second_value : first_value;
          if (w.code_byte == LEN_HOLD) begin
            run_length = 32'(LEN_HOLD_RUN);
          end else begin
            run_length = 32'(w.code_byte);
            use_second = !use_second;
          end
          queue_run(run_value, run_length);
        end
      endcase
    end else if (phase == PH_HEAD0) begin
      held_length = w.code_byte;
      phase = PH_HEAD1;
    end else begin
      queue_run(w.code_byte, 32'(held_length));
      phase = PH_HEAD0;
    end
    if (w.stream_last) begin
      restart_image();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decode_mode = MODE_BINARY;
      voxel_total = '0;
      first_value = '0;
      second_value = '0;
      held_length = '0;
      restart_image();
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DECODE_MODE) begin
          decode_mode = pwdata[0];
        end else begin
          voxel_total = pwdata;
        end
        restart_image();
      end
      if (code_valid && !code_stall) begin
        predict_word(code_word);
      end
      if (voxel_valid && !voxel_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("voxel word with nothing expected", voxel_word.voxel_bytes, '0);
        end else begin
          want = expected_beats.pop_front();
          if (voxel_word.voxel_bytes !== want.voxel_bytes) begin
            report_mismatch("voxel_bytes", voxel_word.voxel_bytes, want.voxel_bytes);
          end
          if (voxel_word.voxel_count !== want.voxel_count) begin
            report_mismatch("voxel_count", 64'(voxel_word.voxel_count),
                            64'(want.voxel_count));
          end
          if (voxel_word.run_end !== want.run_end) begin
            report_mismatch("run_end", 64'(voxel_word.run_end), 64'(want.run_end));
          end
          if (voxel_word.image_done !== want.image_done) begin
            report_mismatch("image_done", 64'(voxel_word.image_done),
                            64'(want.image_done));
          end
        end
      end
    end
    errors <= fail_count;
    pending <= expected_beats.size();
    useful_words <= useful_count;
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import rlvd_pkg::*;

  localparam int   LANES = LANES_DEFAULT;
  localparam logic MODE_PAIRS = ~MODE_BINARY;
  localparam int   RANDOM_WORDS = 450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        code_valid = 1'b0;
  logic        code_stall;
  code_word_t  code_word = '0;
  logic        voxel_valid;
  logic        voxel_stall = 1'b0;
  voxel_word_t voxel_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   errors;
  int   pending;
  int   useful_words;
  logic steady = 1'b0;

  run_length_voxel_decoder_unit #(.LANES(LANES)) dut (
    .clk(clk), .rst(rst),
    .code_valid(code_valid), .code_stall(code_stall), .code_word(code_word),
    .voxel_valid(voxel_valid), .voxel_stall(voxel_stall), .voxel_word(voxel_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  voxel_stream_checker #(.LANES(LANES)) voxel_check (
    .clk(clk), .rst(rst),
    .code_valid(code_valid), .code_stall(code_stall), .code_word(code_word),
    .voxel_valid(voxel_valid), .voxel_stall(voxel_stall), .voxel_word(voxel_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .useful_words(useful_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("run_length_voxel_decoder_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    voxel_stall <= !steady && ($urandom_range(0, 99) < 21);
  end

  task automatic send_code(input logic [7:0] value, input logic last);
    while (!steady && $urandom_range(0, 99) < 21) begin
      code_valid <= 1'b0;
      @(posedge clk);
    end
    code_valid <= 1'b1;
    code_word <= '{code_byte: value, stream_last: last};
    @(posedge clk);
    while (code_stall) begin
      @(posedge clk);
    end
  endtask

  // Holds the sender until every predicted beat has been taken, then lets a
  // header word that makes no beat finish inside the block.
  task automatic drain();
    code_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic mode, input logic [31:0] total);
    drain();
    write_reg(REG_DECODE_MODE, {31'b0, mode});
    write_reg(REG_VOXEL_TOTAL, total);
  endtask

  function automatic logic [7:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return LEN_HOLD;
    end else if (roll < 14) begin
      return 8'd0;
    end else if (roll < 40) begin
      return 8'($urandom_range(1, 16));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_total();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return $urandom_range(1, 400);
    end else if (roll < 75) begin
      return $urandom_range(400, 4000);
    end else if (roll < 82) begin
      return 32'd0;
    end else if (roll < 91) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom();
  endfunction

  task automatic binary_stream(input int runs);
    send_code(8'($urandom()), 1'b0);
    send_code(8'($urandom()), 1'b0);
    for (int i = 0; i < runs; i++) begin
      send_code(pick_length(), i == runs - 1);
    end
  endtask

  task automatic pair_stream(input int pairs);
    logic odd_tail;
    odd_tail = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < pairs; i++) begin
      send_code(pick_length(), 1'b0);
      send_code(8'($urandom()), !odd_tail && (i == pairs - 1));
    end
    if (odd_tail) begin
      send_code(pick_length(), 1'b1);
    end
  endtask

  // Random words with stray stream ends, closed so the next stream starts clean.
  task automatic noise_stream(input int words);
    for (int i = 0; i < words; i++) begin
      send_code(8'($urandom()), ($urandom_range(0, 9) == 0) || (i == words - 1));
    end
  endtask

  initial begin
    int   target;
    int   stream_index;
    logic mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the image is empty, so nothing may come out.
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b1);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'd40, 1'b1);

    // Binary mode: empty run, single voxels, full and partial beats, the
    // hold length, and a final run clipped to the image end.
    configure(MODE_BINARY, 32'd600);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'd0, 1'b0);
    send_code(8'd1, 1'b0);
    send_code(8'd8, 1'b0);
    send_code(LEN_HOLD, 1'b0);
    send_code(8'd254, 1'b0);
    send_code(8'd73, 1'b0);
    send_code(LEN_HOLD, 1'b0);
    send_code(8'd3, 1'b1);

    // Pair mode with the largest image and an odd trailing length.
    configure(MODE_PAIRS, 32'hFFFF_FFFF);
    send_code(8'd255, 1'b0);
    send_code(8'h5A, 1'b0);
    send_code(8'd0, 1'b0);
    send_code(8'h11, 1'b0);
    send_code(8'd1, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'd32, 1'b1);

    // A small image that completes early; the last pair is ignored.
    configure(MODE_PAIRS, 32'd20);
    send_code(8'd16, 1'b0);
    send_code(8'hA5, 1'b0);
    send_code(8'd16, 1'b0);
    send_code(8'h3C, 1'b0);
    send_code(8'd2, 1'b0);
    send_code(8'h77, 1'b1);

    mode = MODE_BINARY;
    configure(mode, pick_total());
    @(posedge clk);
    target = useful_words + RANDOM_WORDS;
    stream_index = 0;
    while (useful_words < target) begin
      steady = (stream_index >= 12) && (stream_index < 20);
      if ($urandom_range(0, 3) == 0) begin
        mode = 1'($urandom_range(0, 1));
        configure(mode, pick_total());
      end else if ($urandom_range(0, 19) == 0) begin
        drain();
      end
      if ($urandom_range(0, 4) == 0) begin
        noise_stream($urandom_range(1, 8));
      end else if (mode == MODE_BINARY) begin
        binary_stream($urandom_range(1, 12));
      end else begin
        pair_stream($urandom_range(1, 8));
      end
      stream_index++;
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("run_length_voxel_decoder_unit regression: pass");
    end else begin
      $display("run_length_voxel_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
